@@ rtl/dgza_pkg.sv @@
// Package for the depth grid zone averager: payload types, codes and sizes.
`default_nettype none
package dgza_pkg;

	// Field and datapath widths
	localparam int DIM_W     = 11;
	localparam int SUM_W     = 32;
	localparam int MEAN_W    = 16;
	localparam int DIV_W     = 18;
	localparam int PROD_W    = 2 * DIM_W;
	localparam int STEP_W    = $clog2(SUM_W);
	localparam int ZONE_COUNT = 16;
	localparam int ZONE_W    = $clog2(ZONE_COUNT);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Default geometry limits
	localparam int DEF_MAX_WIDTH  = 1280;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Register reset values
	localparam logic [DIM_W-1:0]  RST_WIDTH     = 11'd640;
	localparam logic [DIM_W-1:0]  RST_HEIGHT    = 11'd480;
	localparam logic [MEAN_W-1:0] RST_THRESHOLD = 16'd1000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_LOAD,
		ST_STEP,
		ST_STORE,
		ST_EMIT
	} state_t;

	// One pixel request
	typedef struct packed {
		logic [10:0] pixel_x;
		logic [9:0]  pixel_y;
		logic [15:0] depth_value;
		logic        frame_end;
	} in_t;

	// One zone result
	typedef struct packed {
		logic [3:0]  zone_index;
		logic [15:0] zone_mean;
		logic        zone_near;
		logic        steer_right_hint;
		logic        steer_left_hint;
		logic        report_last;
	} out_t;

endpackage
`default_nettype wire

@@ rtl/depth_grid_zone_averager.sv @@
// Depth grid zone averager: 4x4 zone sums of a depth frame and a per-zone mean report.
//
// Pixels enter on the in channel (valid/ready), one request per cycle while
// accumulating. Each depth is added, saturating, into one of 16 zone sums picked
// by comparing 4*x against w, 2w, 3w and 4*y against h, 2h, 3h.
// The pixel marked frame_end starts a report: in_ready drops, and one shared
// restoring divider (one quotient bit per cycle) works out each zone mean as
// sum / floor(w*h/16). Each zone takes a load, 32 divider steps and a store, and
// the first result is offered once all 16 means are stored.
// The 16 results then leave on the out channel, zone 0 to 15, one per cycle
// while out_ready is high; a stall simply holds the current result. The sums
// are cleared once all means are stored; in_ready returns after the result
// marked report_last is taken.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while idle; the block does not enforce this. Reset loads the
// default geometry and threshold, clears the sums and returns the block to idle.
`default_nettype none
module depth_grid_zone_averager #(
	parameter int MAX_WIDTH  = dgza_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dgza_pkg::DEF_MAX_HEIGHT
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [dgza_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [dgza_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  dgza_pkg::in_t                         in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output dgza_pkg::out_t                        out_data
);
	import dgza_pkg::*;

	localparam int CMP_W = DIM_W + 2;

	state_t state_q, state_d;

	logic [DIM_W-1:0]  width_q, height_q;
	logic [MEAN_W-1:0] thresh_q;
	in_t               pix_q;
	logic [SUM_W-1:0]  sums_q [ZONE_COUNT];
	logic [MEAN_W-1:0] mean_q [ZONE_COUNT];
	logic [ZONE_COUNT-1:0] near_q;
	logic              right_q, left_q;
	logic [DIV_W-1:0]  divisor_q, rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic [ZONE_W-1:0] zone_q;

	logic in_acc, out_acc;

	// Clamped geometry
	logic [DIM_W-1:0] w_cl, h_cl;
	always_comb begin
		w_cl = width_q;
		if (width_q < DIM_W'(4)) begin
			w_cl = DIM_W'(4);
		end else if ({2'b00, width_q} > CMP_W'(MAX_WIDTH)) begin
			w_cl = DIM_W'(MAX_WIDTH);
		end
		h_cl = height_q;
		if (height_q < DIM_W'(4)) begin
			h_cl = DIM_W'(4);
		end else if ({2'b00, height_q} > CMP_W'(MAX_HEIGHT)) begin
			h_cl = DIM_W'(MAX_HEIGHT);
		end
	end

	// Zone of the held pixel: count boundaries passed, saturates at 3
	logic [CMP_W-1:0] x4, y4, w1, w2, w3, h1, h2, h3;
	logic [1:0]       col, row;
	logic [ZONE_W-1:0] pix_zone;
	assign x4 = {pix_q.pixel_x, 2'b00};
	assign y4 = {1'b0, pix_q.pixel_y, 2'b00};
	assign w1 = {2'b00, w_cl};
	assign w2 = {1'b0, w_cl, 1'b0};
	assign w3 = w1 + w2;
	assign h1 = {2'b00, h_cl};
	assign h2 = {1'b0, h_cl, 1'b0};
	assign h3 = h1 + h2;
	assign col = 2'(x4 >= w1) + 2'(x4 >= w2) + 2'(x4 >= w3);
	assign row = 2'(y4 >= h1) + 2'(y4 >= h2) + 2'(y4 >= h3);
	assign pix_zone = {row, col};

	// Saturating accumulate
	logic [SUM_W:0]   acc_wide;
	logic [SUM_W-1:0] acc_sat;
	assign acc_wide = {1'b0, sums_q[pix_zone]} + (SUM_W+1)'(pix_q.depth_value);
	assign acc_sat  = acc_wide[SUM_W] ? {SUM_W{1'b1}} : acc_wide[SUM_W-1:0];

	// Divisor from the geometry, registered before use
	logic [PROD_W-1:0] area;
	assign area = w_cl * h_cl;

	// Shared divider step
	logic [DIV_W:0]   trial;
	logic             q_bit;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign q_bit = trial >= {1'b0, divisor_q};

	// Mean saturation and near test
	logic [MEAN_W-1:0] mean_sat;
	logic              mean_near;
	assign mean_sat  = (quo_q[SUM_W-1:MEAN_W] != '0) ? {MEAN_W{1'b1}} : quo_q[MEAN_W-1:0];
	assign mean_near = mean_sat < thresh_q;

	// Handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_ACC:  in_ready = !pix_q.frame_end;
			ST_EMIT: out_valid = 1'b1;
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Result payload
	always_comb begin
		out_data.zone_index       = zone_q;
		out_data.zone_mean        = mean_q[zone_q];
		out_data.zone_near        = near_q[zone_q];
		out_data.steer_right_hint = right_q;
		out_data.steer_left_hint  = left_q;
		out_data.report_last      = zone_q == ZONE_W'(ZONE_COUNT - 1);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_ACC;
			end
			ST_ACC: begin
				if (pix_q.frame_end) state_d = ST_LOAD;
				else if (!in_acc) state_d = ST_IDLE;
			end
			ST_LOAD: state_d = ST_STEP;
			ST_STEP: begin
				if (step_q == STEP_W'(SUM_W - 1)) state_d = ST_STORE;
			end
			ST_STORE: begin
				if (zone_q == ZONE_W'(ZONE_COUNT - 1)) state_d = ST_EMIT;
				else state_d = ST_LOAD;
			end
			ST_EMIT: begin
				if (out_acc && out_data.report_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			thresh_q <= RST_THRESHOLD;
			zone_q   <= '0;
			step_q   <= '0;
			right_q  <= 1'b0;
			left_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:    width_q  <= cfg_data[DIM_W-1:0];
					CFG_FRAME_HEIGHT:   height_q <= cfg_data[DIM_W-1:0];
					CFG_NEAR_THRESHOLD: thresh_q <= cfg_data[MEAN_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_ACC: begin
					if (pix_q.frame_end) begin
						zone_q  <= '0;
						right_q <= 1'b0;
						left_q  <= 1'b0;
					end
				end
				ST_LOAD: step_q <= '0;
				ST_STEP: step_q <= step_q + STEP_W'(1);
				ST_STORE: begin
					if (mean_near) begin
						if (!zone_q[1]) right_q <= 1'b1;
						else left_q <= 1'b1;
					end
					zone_q <= zone_q + ZONE_W'(1);
				end
				ST_EMIT: begin
					if (out_acc) zone_q <= zone_q + ZONE_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Zone sums: accumulate per pixel, cleared once all means are stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ZONE_COUNT; i++) sums_q[i] <= '0;
		end else if (state_q == ST_ACC) begin
			sums_q[pix_zone] <= acc_sat;
		end else if (state_q == ST_STORE && zone_q == ZONE_W'(ZONE_COUNT - 1)) begin
			for (int i = 0; i < ZONE_COUNT; i++) sums_q[i] <= '0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) pix_q <= in_data;
		case (state_q)
			ST_ACC: begin
				if (pix_q.frame_end) divisor_q <= DIV_W'(area >> 4);
			end
			ST_LOAD: begin
				rem_q <= '0;
				quo_q <= sums_q[zone_q];
			end
			ST_STEP: begin
				rem_q <= q_bit ? DIV_W'(trial - {1'b0, divisor_q}) : trial[DIV_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], q_bit};
			end
			ST_STORE: begin
				mean_q[zone_q] <= mean_sat;
				near_q[zone_q] <= mean_near;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	// Never take pixels while a report is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid both high");

	// A frame end request closes the input until the report is out
	a_frame_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.frame_end |=> !in_ready)
		else $error("input open after frame end");

	// Divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> rem_q < divisor_q)
		else $error("divider remainder out of range");

	// After the last result the block is ready again with cleared sums
	a_report_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.report_last |=> in_ready && sums_q[0] == '0)
		else $error("block not idle after report");
`endif

endmodule
`default_nettype wire

@@ test/tb_depth_grid_zone_averager.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the depth grid zone averager, with a zone-mean predictor.
module tb_depth_grid_zone_averager;
	import dgza_pkg::*;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 410;
	localparam int CALM_FROM = 350;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1500000;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	// One line of the directed plan: a pixel request or a register write
	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		in_t px;
		bit typed;
		logic [ZONE_W-1:0] t_zone;
		logic [MEAN_W-1:0] t_mean;
		logic t_near;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// Predictor state
	logic [DIM_W-1:0] reg_width;
	logic [DIM_W-1:0] reg_height;
	logic [MEAN_W-1:0] reg_thresh;
	logic [SUM_W-1:0] zone_acc [ZONE_COUNT];
	out_t pending_zones[$];

	plan_row_t plan[$];
	out_t want;
	out_t fix;
	in_t px;
	int errors;
	int pixels_sent;
	int frames_seen;
	int results_seen;
	int rand_items;
	int cycle_count;
	int slot;
	int n_px;
	int w_eff;
	int h_eff;
	bit calm_tail;
	bit dirty;
	bit sweep;

	depth_grid_zone_averager DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Geometry register as used: saturated into [4, hi]
	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
		if (v < 4) return 4;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	// Grid column or row of a position; outside the frame lands in the last one
	function automatic int unsigned grid_cell(input int unsigned pos, input int unsigned dim);
		int unsigned g;
		g = pos * 4 / dim;
		return (g > 3) ? 3 : g;
	endfunction

	// Accumulate one accepted pixel; on frame end queue the 16 zone results
	task automatic fold_pixel(input in_t p);
		int unsigned w, h, div, m;
		logic [ZONE_W-1:0] zone;
		int k;
		logic [SUM_W:0] s;
		logic right_h, left_h;
		logic [MEAN_W-1:0] means [ZONE_COUNT];
		logic nears [ZONE_COUNT];
		out_t r;
		w = eff_dim(reg_width, MAX_W);
		h = eff_dim(reg_height, MAX_H);
		zone = ZONE_W'(grid_cell(32'(p.pixel_y), h) * 4 + grid_cell(32'(p.pixel_x), w));
		s = {1'b0, zone_acc[zone]} + (SUM_W+1)'(p.depth_value);
		zone_acc[zone] = s[SUM_W] ? '1 : s[SUM_W-1:0];
		if (!p.frame_end) return;
		div = w * h / 16;
		right_h = 1'b0;
		left_h = 1'b0;
		for (k = 0; k < ZONE_COUNT; k++) begin
			m = zone_acc[k] / div;
			means[k] = (m > 65535) ? 16'hFFFF : m[MEAN_W-1:0];
			nears[k] = means[k] < reg_thresh;
			if (nears[k]) begin
				if ((k % 4) < 2) right_h = 1'b1;
				else left_h = 1'b1;
			end
		end
		for (k = 0; k < ZONE_COUNT; k++) begin
			r.zone_index = k[ZONE_W-1:0];
			r.zone_mean = means[k];
			r.zone_near = nears[k];
			r.steer_right_hint = right_h;
			r.steer_left_hint = left_h;
			r.report_last = (k == ZONE_COUNT - 1);
			pending_zones.push_back(r);
			zone_acc[k] = '0;
		end
		frames_seen++;
	endtask

	// Register write; held for one edge, then cfg_we is low again before the task returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH: reg_width = val[DIM_W-1:0];
			CFG_FRAME_HEIGHT: reg_height = val[DIM_W-1:0];
			CFG_NEAR_THRESHOLD: reg_thresh = val[MEAN_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Present one pixel and hold it until the request is taken
	task automatic send_pixel(input in_t p);
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fold_pixel(p);
		pixels_sent++;
	endtask

	task automatic sender_gap();
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Block idle: every report out, plus margin
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_zones.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_dim(input int unsigned hi);
		case ($urandom_range(0, 19)) inside
			[0:11]: return CFG_DATA_W'($urandom_range(4, 32));
			[12:14]: return CFG_DATA_W'($urandom_range(33, hi));
			15: return CFG_DATA_W'(hi);
			16: return CFG_DATA_W'($urandom_range(0, 3));
			17: return CFG_DATA_W'($urandom_range(hi + 1, 2047));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic rand_config();
		if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_WIDTH, pick_dim(MAX_W));
		if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_HEIGHT, pick_dim(MAX_H));
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 5))
				0: write_reg(CFG_NEAR_THRESHOLD, '0);
				1: write_reg(CFG_NEAR_THRESHOLD, '1);
				2: write_reg(CFG_NEAR_THRESHOLD, CFG_DATA_W'($urandom_range(0, 512)));
				default: write_reg(CFG_NEAR_THRESHOLD, CFG_DATA_W'($urandom));
			endcase
		end
		if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
	endtask

	// Random pixel, mostly inside the frame
	function automatic in_t rand_pixel(input int unsigned w, input int unsigned h);
		in_t p;
		case ($urandom_range(0, 19)) inside
			[0:1]: p.pixel_x = 11'($urandom);
			2: p.pixel_x = 11'(w - 1);
			3: p.pixel_x = '0;
			default: p.pixel_x = 11'($urandom_range(0, w - 1));
		endcase
		case ($urandom_range(0, 19)) inside
			[0:1]: p.pixel_y = 10'($urandom);
			2: p.pixel_y = 10'(h - 1);
			3: p.pixel_y = '0;
			default: p.pixel_y = 10'($urandom_range(0, h - 1));
		endcase
		case ($urandom_range(0, 9))
			0: p.depth_value = '0;
			1: p.depth_value = '1;
			2: p.depth_value = 16'($urandom_range(0, 255));
			default: p.depth_value = 16'($urandom);
		endcase
		p.frame_end = 1'b0;
		return p;
	endfunction

	task automatic plan_px(input int x, input int y, input int d, input bit fe);
		plan_row_t r;
		r.kind = ROW_PIXEL;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.px.pixel_x = 11'(x);
		r.px.pixel_y = 10'(y);
		r.px.depth_value = 16'(d);
		r.px.frame_end = fe;
		r.typed = 1'b0;
		r.t_zone = '0;
		r.t_mean = '0;
		r.t_near = 1'b0;
		plan.push_back(r);
	endtask

	task automatic plan_wr(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_val = val;
		r.px = '0;
		r.typed = 1'b0;
		r.t_zone = '0;
		r.t_mean = '0;
		r.t_near = 1'b0;
		plan.push_back(r);
	endtask

	// Known answer for one zone of the report the last row closes
	task automatic plan_typed(input int zone, input int mean, input bit near_bit);
		plan_row_t r;
		r = plan[plan.size() - 1];
		r.typed = 1'b1;
		r.t_zone = ZONE_W'(zone);
		r.t_mean = MEAN_W'(mean);
		r.t_near = near_bit;
		plan[plan.size() - 1] = r;
	endtask

	task automatic flag_field(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_zones.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got zone %0d mean %0d",
					$time, out_data.zone_index, out_data.zone_mean);
			end else begin
				want = pending_zones.pop_front();
				flag_field("zone_index", 32'(want.zone_index), 32'(out_data.zone_index));
				flag_field("zone_mean", 32'(want.zone_mean), 32'(out_data.zone_mean));
				flag_field("zone_near", 32'(want.zone_near), 32'(out_data.zone_near));
				flag_field("steer_right_hint", 32'(want.steer_right_hint),
					32'(out_data.steer_right_hint));
				flag_field("steer_left_hint", 32'(want.steer_left_hint),
					32'(out_data.steer_left_hint));
				flag_field("report_last", 32'(want.report_last), 32'(out_data.report_last));
				results_seen++;
			end
		end
	end

	// Receiver: ready with random stall bursts, none in the tail
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm_tail && $urandom_range(0, 1) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_depth_grid_zone_averager: FAIL");
		$finish;
	end

	// Stimulus
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm_tail = 1'b0;
		dirty = 1'b0;
		errors = 0;
		pixels_sent = 0;
		frames_seen = 0;
		results_seen = 0;
		rand_items = 0;
		reg_width = RST_WIDTH;
		reg_height = RST_HEIGHT;
		reg_thresh = RST_THRESHOLD;
		for (int k = 0; k < ZONE_COUNT; k++) zone_acc[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry 640x480: one full-scale pixel, then out-of-frame corner
		plan_px(0, 0, 65535, 1);
		plan_typed(0, 3, 1);
		plan_px(639, 479, 0, 0);
		plan_px(2047, 1023, 40000, 0);
		plan_px(320, 240, 12345, 1);
		// 4x4 frame, divisor 1: two full pixels saturate the mean; nothing near
		plan_wr(CFG_FRAME_WIDTH, 16'd4);
		plan_wr(CFG_FRAME_HEIGHT, 16'd4);
		plan_wr(CFG_NEAR_THRESHOLD, 16'd0);
		plan_px(0, 0, 65535, 0);
		plan_px(0, 0, 65535, 0);
		plan_px(3, 3, 1, 1);
		plan_typed(0, 65535, 0);
		// Width below range, height above range, every zone near, spare index ignored
		plan_wr(CFG_FRAME_WIDTH, 16'd0);
		plan_wr(CFG_FRAME_HEIGHT, 16'h07FF);
		plan_wr(CFG_NEAR_THRESHOLD, 16'hFFFF);
		plan_wr(CFG_SPARE, 16'h1234);
		plan_px(1, 512, 65535, 0);
		plan_px(2, 1023, 256, 1);
		plan_typed(9, 255, 1);
		// Largest frame
		plan_wr(CFG_FRAME_WIDTH, 16'd1280);
		plan_wr(CFG_FRAME_HEIGHT, 16'd1024);
		plan_wr(CFG_NEAR_THRESHOLD, 16'd1);
		plan_px(640, 512, 65535, 0);
		plan_px(1279, 1023, 65535, 1);
		plan_typed(15, 0, 1);
		// Upper data bits dropped (8x8); left half far, so only steer-left
		plan_wr(CFG_FRAME_WIDTH, 16'hF808);
		plan_wr(CFG_FRAME_HEIGHT, 16'h8008);
		plan_wr(CFG_NEAR_THRESHOLD, 16'd100);
		for (int k = 0; k < 8; k++) plan_px((k % 2) * 2, (k / 2) * 2, 1000, k == 7);

		// Directed walk
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (dirty) begin
					settle();
					dirty = 1'b0;
				end
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_pixel(plan[i].px);
				dirty = 1'b1;
				if (plan[i].typed) begin
					slot = pending_zones.size() - ZONE_COUNT + plan[i].t_zone;
					fix = pending_zones[slot];
					fix.zone_mean = plan[i].t_mean;
					fix.zone_near = plan[i].t_near;
					pending_zones[slot] = fix;
				end
				sender_gap();
			end
		end

		// Random frames: sweeps of all zones or short scattered frames
		while (rand_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				settle();
				rand_config();
			end
			w_eff = eff_dim(reg_width, MAX_W);
			h_eff = eff_dim(reg_height, MAX_H);
			sweep = ($urandom_range(0, 2) == 0);
			n_px = sweep ? ZONE_COUNT : $urandom_range(1, 24);
			for (int k = 0; k < n_px; k++) begin
				px = rand_pixel(w_eff, h_eff);
				if (sweep) begin
					px.pixel_x = 11'(((k % 4) * w_eff + 3) / 4);
					px.pixel_y = 10'(((k / 4) * h_eff + 3) / 4);
				end
				px.frame_end = (k == n_px - 1);
				send_pixel(px);
				rand_items++;
				calm_tail = (rand_items >= CALM_FROM);
				sender_gap();
			end
		end

		// Drain and watch for stray results
		in_valid <= 1'b0;
		while (pending_zones.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d pixel requests in %0d frames, %0d zone results checked.",
			pixels_sent, frames_seen, results_seen);
		$display("Geometry went from 4x4 to 1280x1024 with out-of-range values and stalls on both sides.");
		if (errors == 0)
			$display("tb_depth_grid_zone_averager: PASS");
		else
			$display("tb_depth_grid_zone_averager: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/dgza_pkg.sv
rtl/depth_grid_zone_averager.sv
test/tb_depth_grid_zone_averager.sv
